// ===== rtl/core/nhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nhs_pkg: shared types and constants for the next-hop select core
// Item kinds, table entry layout, write-port bundle and the link cost function.
// ---------------------------------------------------------------------------
package nhs_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned RSSI_W  = 8;
	localparam int unsigned BATT_W  = 7;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned HOPS_W  = 7;
	localparam int unsigned COST_W  = 14;

	localparam logic [1:0] KIND_UPDATE  = 2'd0;
	localparam logic [1:0] KIND_DEAD    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;
	localparam logic [1:0] KIND_QUERY   = 2'd3;

	localparam logic [HOPS_W-1:0] HOPS_NONE   = 7'd99;
	localparam logic [HOPS_W-1:0] HOPS_DIRECT = 7'd1;
	localparam logic [HOPS_W-1:0] HOPS_RELAY  = 7'd2;
	localparam logic [COST_W-1:0] RELAY_EXTRA = 14'd3000;
	localparam logic [BATT_W-1:0] BATT_MAX    = 7'd100;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd30000;

	typedef struct packed {
		logic [ID_W-1:0]   node_id;
		logic [RSSI_W-1:0] rssi;
		logic [BATT_W-1:0] battery;
		logic [TIME_W-1:0] last_ms;
	} nhs_entry_t;

	typedef struct packed {
		logic       we_entry;
		logic       we_alive;
		logic       alive;
		nhs_entry_t entry;
	} nhs_wr_t;

	// cost in units of 1/6000, rssi penalty clamped to 0..60 dB below -40 dBm
	function automatic logic [COST_W-1:0] link_cost(input logic [RSSI_W-1:0] rssi,
			input logic [BATT_W-1:0] battery, input logic alert);
		logic signed [9:0] d;
		logic [5:0]        du;
		logic [6:0]        bp;
		logic [COST_W-1:0] c;
		d = -10'sd40 - $signed({{2{rssi[7]}}, rssi});
		if (d < 10'sd0) begin
			du = 6'd0;
		end else if (d > 10'sd60) begin
			du = 6'd60;
		end else begin
			du = d[5:0];
		end
		bp = BATT_MAX - battery;
		if (alert) begin
			c = 14'd3000 + COST_W'(du) * 14'd40 + COST_W'(bp) * 14'd3;
		end else begin
			c = 14'd1800 + COST_W'(du) * 14'd20 + COST_W'(bp) * 14'd24;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nhs_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nhs_table: neighbour table storage
// One registered read port and one write port; alive flags written on their own.
// ---------------------------------------------------------------------------
module nhs_table #(
	parameter int unsigned ENTRIES = nhs_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic               clk,
	input  wire logic               rd_en,
	input  wire logic [IDX_W-1:0]   rd_addr,
	output nhs_pkg::nhs_entry_t     rd_entry,
	output logic                    rd_alive,
	input  wire logic [IDX_W-1:0]   wr_addr,
	input  wire nhs_pkg::nhs_wr_t   wr
);

	nhs_pkg::nhs_entry_t entry_mem [ENTRIES];
	logic                alive_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we_entry) begin
			entry_mem[wr_addr] <= wr.entry;
		end
		if (wr.we_alive) begin
			alive_mem[wr_addr] <= wr.alive;
		end
		if (rd_en) begin
			rd_entry <= entry_mem[rd_addr];
			rd_alive <= alive_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/neighbour_table_next_hop_select_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// neighbour_table_next_hop_select_core: neighbour table with next-hop choice
// Keeps neighbour entries, ages them out and picks the cheapest route.
// ---------------------------------------------------------------------------
// usage
// s_* carries command items: tuser is the kind (update, mark dead, check
// timeouts, query), tdata the operands. every item gives exactly one result
// item on m_*. cfg_we/cfg_wdata set the offline timeout, idle only.
// each item walks the stored entries through one read port and one shared
// cost/compare unit, one entry per cycle; the result is then loaded into the
// output register in the finish step, and s_tready stays low until the core
// is back in idle, where the next item can be accepted.
// the result sits in an output register, so the next item is accepted while
// it waits; if the receiver still stalls when the next result is ready, the
// core holds in its final step until m_tready frees the register.
// reset empties the table (entry count zero) and loads a timeout of 30000 ms;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module neighbour_table_next_hop_select_core #(
	parameter int unsigned TABLE_ENTRIES = nhs_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // node_id, rssi, battery, alert_mode, now_ms
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // route_valid, next_hop, hop_count, route_cost,
	                                    // update_dropped, zero pad
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            rd_idx_q;
	logic                        ev_s1;
	logic [IDX_W-1:0]            ev_idx_s1;
	logic [31:0]                 timeout_q;

	logic [1:0]                  kind_q;
	logic [nhs_pkg::ID_W-1:0]    id_q;
	logic [nhs_pkg::RSSI_W-1:0]  rssi_q;
	logic [nhs_pkg::BATT_W-1:0]  batt_q;
	logic                        alert_q;
	logic [nhs_pkg::TIME_W-1:0]  now_q;

	logic                        found_q;
	logic [IDX_W-1:0]            found_idx_q;
	logic                        dvalid_q;
	logic [nhs_pkg::COST_W-1:0]  dbest_q;
	logic                        rvalid_q;
	logic [nhs_pkg::COST_W-1:0]  rbest_q;
	logic [nhs_pkg::ID_W-1:0]    rhop_q;

	logic                        m_tvalid_q;
	logic [31:0]                 m_tdata_q;

	logic                        rd_en;
	nhs_pkg::nhs_entry_t         rd_entry;
	logic                        rd_alive;
	logic [IDX_W-1:0]            wr_addr;
	nhs_pkg::nhs_wr_t            wr;

	logic                        out_free;
	logic                        full;
	logic                        ev_match;
	logic                        ev_expired;
	logic [nhs_pkg::TIME_W-1:0]  ev_age;
	logic [nhs_pkg::COST_W-1:0]  ev_cost;
	logic [nhs_pkg::BATT_W-1:0]  batt_sat;
	logic                        append;

	logic                        res_valid;
	logic [nhs_pkg::ID_W-1:0]    res_hop;
	logic [nhs_pkg::HOPS_W-1:0]  res_hops;
	logic [nhs_pkg::COST_W-1:0]  res_cost;
	logic                        res_dropped;

	nhs_table #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_idx_q[IDX_W-1:0]),
		.rd_entry (rd_entry),
		.rd_alive (rd_alive),
		.wr_addr  (wr_addr),
		.wr       (wr)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (count_q == CNT_W'(TABLE_ENTRIES));
	assign rd_en    = (state_q == S_SCAN) && (rd_idx_q < count_q);
	assign batt_sat = (s_tdata[22:16] > nhs_pkg::BATT_MAX) ? nhs_pkg::BATT_MAX
		: s_tdata[22:16];

	// shared unit: evaluates the entry read in the previous cycle
	assign ev_match   = (rd_entry.node_id == id_q);
	assign ev_age     = now_q - rd_entry.last_ms;
	assign ev_expired = rd_alive && (ev_age > timeout_q);
	assign ev_cost    = nhs_pkg::link_cost(rd_entry.rssi, rd_entry.battery, alert_q);

	assign append = (kind_q == nhs_pkg::KIND_UPDATE) && !found_q && !full;

	always_comb begin
		wr                = '0;
		wr.entry.node_id  = id_q;
		wr.entry.rssi     = rssi_q;
		wr.entry.battery  = batt_q;
		wr.entry.last_ms  = now_q;
		wr_addr           = ev_idx_s1;
		if (state_q == S_SCAN && ev_s1) begin
			if ((kind_q == nhs_pkg::KIND_DEAD && ev_match) ||
					(kind_q == nhs_pkg::KIND_TIMEOUT && ev_expired)) begin
				wr.we_alive = 1'b1;
			end
		end else if (state_q == S_FINISH && out_free &&
				kind_q == nhs_pkg::KIND_UPDATE && (found_q || !full)) begin
			wr.we_entry = 1'b1;
			wr.we_alive = 1'b1;
			wr.alive    = 1'b1;
			wr_addr     = found_q ? found_idx_q : count_q[IDX_W-1:0];
		end
	end

	always_comb begin
		res_valid   = 1'b0;
		res_hop     = '0;
		res_hops    = nhs_pkg::HOPS_NONE;
		res_cost    = '0;
		res_dropped = (kind_q == nhs_pkg::KIND_UPDATE) && !found_q && full;
		if (kind_q == nhs_pkg::KIND_QUERY) begin
			if (dvalid_q) begin
				res_valid = 1'b1;
				res_hop   = id_q;
				res_hops  = nhs_pkg::HOPS_DIRECT;
				res_cost  = dbest_q;
			end else if (rvalid_q) begin
				res_valid = 1'b1;
				res_hop   = rhop_q;
				res_hops  = nhs_pkg::HOPS_RELAY;
				res_cost  = rbest_q + nhs_pkg::RELAY_EXTRA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			ev_s1       <= 1'b0;
			ev_idx_s1   <= '0;
			timeout_q   <= nhs_pkg::TIMEOUT_RST;
			kind_q      <= nhs_pkg::KIND_UPDATE;
			id_q        <= '0;
			rssi_q      <= '0;
			batt_q      <= '0;
			alert_q     <= 1'b0;
			now_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			dvalid_q    <= 1'b0;
			dbest_q     <= '0;
			rvalid_q    <= 1'b0;
			rbest_q     <= '0;
			rhop_q      <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			// the finish step reloads the output register on its own
			if (m_tvalid_q && m_tready && state_q != S_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q   <= s_tuser;
						id_q     <= s_tdata[7:0];
						rssi_q   <= s_tdata[15:8];
						batt_q   <= batt_sat;
						alert_q  <= s_tdata[23];
						now_q    <= s_tdata[55:24];
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						dvalid_q <= 1'b0;
						rvalid_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					ev_s1     <= rd_en;
					ev_idx_s1 <= rd_idx_q[IDX_W-1:0];
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (ev_s1) begin
						if (kind_q == nhs_pkg::KIND_UPDATE && !found_q && ev_match) begin
							found_q     <= 1'b1;
							found_idx_q <= ev_idx_s1;
						end
						// one pass tracks the best direct hop and the best relay
						if (kind_q == nhs_pkg::KIND_QUERY && rd_alive) begin
							if (ev_match && (!dvalid_q || ev_cost < dbest_q)) begin
								dvalid_q <= 1'b1;
								dbest_q  <= ev_cost;
							end
							if (!rvalid_q || ev_cost < rbest_q) begin
								rvalid_q <= 1'b1;
								rbest_q  <= ev_cost;
								rhop_q   <= rd_entry.node_id;
							end
						end
					end
					if (rd_idx_q == count_q && !ev_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, res_dropped, res_cost, res_hops, res_hop,
							res_valid};
						if (append) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("entry count moved by other than one");

	a_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && wr.we_alive) |->
		(kind_q == nhs_pkg::KIND_DEAD || kind_q == nhs_pkg::KIND_TIMEOUT))
		else $error("alive flag written during scan of wrong kind");

	a_eval_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s1 |-> (state_q == S_SCAN))
		else $error("entry evaluated outside scan");

	a_route_hops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[0]) |->
		(m_tdata_q[15:9] == nhs_pkg::HOPS_DIRECT || m_tdata_q[15:9] == nhs_pkg::HOPS_RELAY))
		else $error("route result with bad hop count");

endmodule
`default_nettype wire

// ===== dv/neighbour_table_next_hop_select_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbour_table_next_hop_select_core_test: stream-level check of the core
// Drives command items with random gaps and result stalls, predicts every
// result from its own copy of the neighbour table, and compares field by field.
// ---------------------------------------------------------------------------
module neighbour_table_next_hop_select_core_test;

	import nhs_pkg::*;

	localparam int unsigned ENTRIES    = TABLE_ENTRIES_DEF;
	localparam int unsigned POOL_SIZE  = 20;
	localparam int unsigned PHASE_LEN  = 306;
	localparam int unsigned CYCLE_CAP  = 400000;

	typedef struct {
		logic [1:0]        kind;
		logic [7:0]        node_id;
		logic signed [7:0] rssi;
		logic [6:0]        battery;
		logic              alert;
		logic [31:0]       now_ms;
	} nhs_cmd_t;

	typedef struct {
		logic        route_valid;
		logic [7:0]  next_hop;
		logic [6:0]  hop_count;
		logic [13:0] route_cost;
		logic        update_dropped;
	} nhs_route_t;

	class route_scoreboard;
		logic [7:0]        ids [ENTRIES];
		logic signed [7:0] rssi_of [ENTRIES];
		logic [6:0]        batt_of [ENTRIES];
		logic [31:0]       heard [ENTRIES];
		bit                alive [ENTRIES];
		int unsigned       used;
		logic [31:0]       offline_ms;
		nhs_route_t        routes_due [$];
		int unsigned       failures, checked;
		int unsigned       n_kind [4];
		int unsigned       n_dropped, n_direct, n_relay, n_none;

		function new();
			used = 0;
			offline_ms = TIMEOUT_RST;
			failures = 0;
			checked = 0;
			n_dropped = 0;
			n_direct = 0;
			n_relay = 0;
			n_none = 0;
			foreach (n_kind[k]) n_kind[k] = 0;
		endfunction

		function void set_timeout(logic [31:0] v);
			offline_ms = v;
		endfunction

		function int unsigned pending();
			return routes_due.size();
		endfunction

		// cost in 1/6000 units: rssi penalty clamped to 0..60 below -40 dBm
		function int unsigned link_price(logic signed [7:0] r, logic [6:0] b, logic alert);
			int d;
			int bp;
			d = -40 - int'(r);
			if (d < 0) d = 0;
			if (d > 60) d = 60;
			bp = 100 - int'(b);
			if (alert) return 3000 + 40 * d + 3 * bp;
			return 1800 + 20 * d + 24 * bp;
		endfunction

		function void note_command(nhs_cmd_t c);
			nhs_route_t  res;
			logic [6:0]  b;
			logic [31:0] age;
			bit          found;
			int unsigned best, price;
			res.route_valid = 1'b0;
			res.next_hop = 8'd0;
			res.hop_count = HOPS_NONE;
			res.route_cost = 14'd0;
			res.update_dropped = 1'b0;
			b = (c.battery > BATT_MAX) ? BATT_MAX : c.battery;
			found = 0;
			best = 0;
			n_kind[c.kind]++;
			case (c.kind)
				KIND_UPDATE: begin
					for (int i = 0; i < used && !found; i++) begin
						if (ids[i] == c.node_id) begin
							rssi_of[i] = c.rssi;
							batt_of[i] = b;
							heard[i] = c.now_ms;
							alive[i] = 1;
							found = 1;
						end
					end
					if (!found) begin
						if (used < ENTRIES) begin
							ids[used] = c.node_id;
							rssi_of[used] = c.rssi;
							batt_of[used] = b;
							heard[used] = c.now_ms;
							alive[used] = 1;
							used++;
						end else begin
							res.update_dropped = 1'b1;
							n_dropped++;
						end
					end
				end
				KIND_DEAD: begin
					for (int i = 0; i < used; i++)
						if (ids[i] == c.node_id) alive[i] = 0;
				end
				KIND_TIMEOUT: begin
					for (int i = 0; i < used; i++) begin
						age = c.now_ms - heard[i];
						if (alive[i] && age > offline_ms) alive[i] = 0;
					end
				end
				KIND_QUERY: begin
					for (int i = 0; i < used; i++) begin
						if (!alive[i] || ids[i] != c.node_id) continue;
						price = link_price(rssi_of[i], batt_of[i], c.alert);
						if (!res.route_valid || price < best) begin
							best = price;
							res.route_valid = 1'b1;
							res.next_hop = c.node_id;
							res.hop_count = HOPS_DIRECT;
						end
					end
					// relays only when the destination is not an alive neighbour
					if (!res.route_valid) begin
						for (int i = 0; i < used; i++) begin
							if (!alive[i]) continue;
							price = link_price(rssi_of[i], batt_of[i], c.alert) + RELAY_EXTRA;
							if (!res.route_valid || price < best) begin
								best = price;
								res.route_valid = 1'b1;
								res.next_hop = ids[i];
								res.hop_count = HOPS_RELAY;
							end
						end
					end
					if (res.route_valid) res.route_cost = best[13:0];
					if (res.hop_count == HOPS_DIRECT) n_direct++;
					else if (res.hop_count == HOPS_RELAY) n_relay++;
					else n_none++;
				end
			endcase
			routes_due.push_back(res);
		endfunction

		function void check_result(logic [31:0] word);
			nhs_route_t exp_r;
			if (routes_due.size() == 0) begin
				$error("unexpected result item %h", word);
				failures++;
				return;
			end
			exp_r = routes_due.pop_front();
			checked++;
			if (word[0] !== exp_r.route_valid) begin
				$error("route_valid: expected %0d, actual %0d", exp_r.route_valid, word[0]);
				failures++;
			end
			if (word[8:1] !== exp_r.next_hop) begin
				$error("next_hop: expected %0d, actual %0d", exp_r.next_hop, word[8:1]);
				failures++;
			end
			if (word[15:9] !== exp_r.hop_count) begin
				$error("hop_count: expected %0d, actual %0d", exp_r.hop_count, word[15:9]);
				failures++;
			end
			if (word[29:16] !== exp_r.route_cost) begin
				$error("route_cost: expected %0d, actual %0d", exp_r.route_cost, word[29:16]);
				failures++;
			end
			if (word[30] !== exp_r.update_dropped) begin
				$error("update_dropped: expected %0d, actual %0d",
					exp_r.update_dropped, word[30]);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	route_scoreboard sb;
	bit              calm;
	logic [31:0]     clock_ms;
	logic [7:0]      pool [POOL_SIZE];
	int unsigned     cycles;
	int unsigned     n_settings;

	neighbour_table_next_hop_select_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_item(input nhs_cmd_t c);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata <= {c.now_ms, c.alert, c.battery, c.rssi, c.node_id};
		s_tuser <= c.kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_command(c);
	endtask

	task automatic send_fields(input logic [1:0] kind, input logic [7:0] id,
			input logic signed [7:0] rssi, input logic [6:0] batt, input logic alert,
			input logic [31:0] now);
		nhs_cmd_t c;
		c.kind = kind;
		c.node_id = id;
		c.rssi = rssi;
		c.battery = batt;
		c.alert = alert;
		c.now_ms = now;
		send_item(c);
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] v);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_timeout(v);
		n_settings++;
	endtask

	// mostly plausible traffic around a running clock, now and then pure noise
	function automatic nhs_cmd_t random_cmd();
		nhs_cmd_t    c;
		int unsigned pick;
		c.node_id = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
			: 8'($urandom);
		c.rssi = 8'($urandom);
		c.battery = 7'($urandom_range(0, 127));
		c.alert = 1'($urandom);
		if ($urandom_range(0, 99) < 2) clock_ms = clock_ms + $urandom;
		else clock_ms = clock_ms + $urandom_range(0, 1500);
		c.now_ms = clock_ms;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			c.kind = 2'($urandom);
			c.node_id = 8'($urandom);
			c.now_ms = $urandom;
		end else if (pick < 48) c.kind = KIND_UPDATE;
		else if (pick < 78) c.kind = KIND_QUERY;
		else if (pick < 90) c.kind = KIND_TIMEOUT;
		else c.kind = KIND_DEAD;
		return c;
	endfunction

	// result side: random stalls per item, checked on the accepting edge
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$error("run did not finish within %0d cycles", CYCLE_CAP);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [31:0] settings [5];
		bit          taken [256];
		int unsigned n;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_UPDATE;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 0;
		n_settings = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: empty table, extremes, ties, revive, timeout edge and wrap
		send_fields(KIND_QUERY, 8'd5, 8'sd0, 7'd50, 1'b0, 32'd0);
		send_fields(KIND_DEAD, 8'd5, 8'sd0, 7'd0, 1'b0, 32'd0);
		send_fields(KIND_TIMEOUT, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd0);
		send_fields(KIND_UPDATE, 8'd0, 8'sd127, 7'd127, 1'b0, 32'd1000);
		send_fields(KIND_UPDATE, 8'd255, -8'sd128, 7'd0, 1'b1, 32'd1000);
		send_fields(KIND_QUERY, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd1000);
		send_fields(KIND_QUERY, 8'd255, 8'sd0, 7'd0, 1'b1, 32'd1000);
		send_fields(KIND_QUERY, 8'd7, 8'sd0, 7'd0, 1'b0, 32'd1000);
		send_fields(KIND_UPDATE, 8'd10, -8'sd60, 7'd50, 1'b0, 32'd2000);
		send_fields(KIND_UPDATE, 8'd11, -8'sd60, 7'd50, 1'b0, 32'd2000);
		send_fields(KIND_DEAD, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd2000);
		send_fields(KIND_DEAD, 8'd255, 8'sd0, 7'd0, 1'b0, 32'd2000);
		send_fields(KIND_QUERY, 8'd0, 8'sd0, 7'd0, 1'b1, 32'd2000);
		send_fields(KIND_UPDATE, 8'd0, -8'sd40, 7'd100, 1'b0, 32'd3000);
		send_fields(KIND_QUERY, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd3000);
		send_fields(KIND_TIMEOUT, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd31000);
		send_fields(KIND_TIMEOUT, 8'd0, 8'sd0, 7'd0, 1'b0, 32'd32001);
		send_fields(KIND_QUERY, 8'd200, 8'sd0, 7'd0, 1'b1, 32'd32001);
		send_fields(KIND_UPDATE, 8'd20, -8'sd100, 7'd101, 1'b0, 32'hFFFF_FF00);
		send_fields(KIND_TIMEOUT, 8'd0, 8'sd0, 7'd0, 1'b0, 32'h0000_0100);
		send_fields(KIND_QUERY, 8'd20, 8'sd0, 7'd0, 1'b1, 32'h0000_0100);
		send_fields(KIND_QUERY, 8'd99, 8'sd0, 7'd0, 1'b0, 32'h0000_0100);

		foreach (taken[k]) taken[k] = 0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			do pool[i] = 8'($urandom); while (taken[pool[i]]);
			taken[pool[i]] = 1;
		end

		settings[0] = 32'd2000;
		settings[1] = 32'd1;
		settings[2] = 32'hFFFF_FFFF;
		settings[3] = TIMEOUT_RST;
		settings[4] = $urandom_range(100, 8000);
		clock_ms = $urandom;
		for (int p = 0; p < 5; p++) begin
			write_timeout(settings[p]);
			// one phase starts just below the time wrap and runs across it
			if (p == 1) clock_ms = 32'hFFFF_0000;
			for (n = 0; n < PHASE_LEN; n++) begin
				if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
				// let every pending result come home before carrying on
				if (p == 2 && n == 150) drain_results();
				send_item(random_cmd());
			end
		end
		calm = 0;

		drain_results();
		repeat (40) @(posedge clk);
		$display("checked %0d results over %0d timeout settings: %0d updates (%0d dropped), %0d mark-dead, %0d timeout checks",
			sb.checked, n_settings, sb.n_kind[KIND_UPDATE], sb.n_dropped,
			sb.n_kind[KIND_DEAD], sb.n_kind[KIND_TIMEOUT]);
		$display("%0d queries: %0d direct, %0d via relay, %0d without route",
			sb.n_kind[KIND_QUERY], sb.n_direct, sb.n_relay, sb.n_none);
		if (sb.failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
